// File: design/snsh_pkg.sv
// Shared constants and register index codes for the sphere-shell snapping unit.
// No dependencies; imported by snap_points_to_sphere_shell, snsh_chk and tb_top.
`default_nettype none

package snsh_pkg;

    // snap ratio register format, unsigned Q8.16
    localparam int RATIO_BITS = 24;
    localparam int RATIO_FRAC = 16;

    // configuration register index
    localparam int CFG_IDX_W = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CENTER_X = 3'd0,
        CFG_CENTER_Y = 3'd1,
        CFG_CENTER_Z = 3'd2,
        CFG_BALL_R   = 3'd3,
        CFG_GRAIN_R  = 3'd4,
        CFG_RATIO    = 3'd5
    } t_cfg_idx;

endpackage

`default_nettype wire

// File: design/snap_points_to_sphere_shell.sv
// Sphere-shell snapping pipeline: top level, register bank and all datapath stages.
// Depends on snsh_pkg.
`default_nettype none

// Channel   Dir  Beat contents (lowest bits first)
// --------  ---  -----------------------------------------------------------
// s (in)    in   tdata: pos_x, pos_y, pos_z (COORD_BITS signed each), zero pad
// m (out)   out  tdata: new_x, new_y, new_z (COORD_BITS signed each), zero pad
//                tuser: moved
// cfg       in   i_cfg_we / i_cfg_idx / i_cfg_data, one register per write
//
// One beat enters per cycle unless the output is stalled; the datapath holds the
// COORD_BITS+1 bit-per-stage square-root stages and the
// COORD_BITS-1 bit-per-stage divider stages.
// All stages advance together; a stalled output beat holds the whole pipe and
// drops o_s_tready, so no beat is lost or repeated.
// Reset is synchronous, active low: valid bits clear and the registers take
// center 0, ball radius 1.0, grain radius 0, ratio 0.5.

module snap_points_to_sphere_shell #(
    parameter int COORD_BITS = 32,
    parameter int FRAC_BITS  = 16,
    localparam int DW_IN  = ((3 * COORD_BITS + 7) / 8) * 8,
    localparam int DW_OUT = ((3 * COORD_BITS + 7) / 8) * 8,
    localparam int CFG_W  = (COORD_BITS > snsh_pkg::RATIO_BITS) ?
                            COORD_BITS : snsh_pkg::RATIO_BITS
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    // configuration
    input  wire logic                           i_cfg_we,
    input  wire logic [snsh_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [CFG_W-1:0]               i_cfg_data,
    // input stream
    input  wire logic                           i_s_tvalid,
    output logic                                o_s_tready,
    input  wire logic [DW_IN-1:0]               i_s_tdata,   // pos_x, pos_y, pos_z
    // output stream
    output logic                                o_m_tvalid,
    input  wire logic                           i_m_tready,
    output logic [DW_OUT-1:0]                   o_m_tdata,   // new_x, new_y, new_z
    output logic                                o_m_tuser    // moved
);
    import snsh_pkg::*;

    localparam int CB   = COORD_BITS;
    localparam int RB   = CB - 1;            // radius width
    localparam int L    = CB + 1;            // length width
    localparam int SQ   = 2 * CB + 2;        // sum of squares width
    localparam int NB   = 2 * CB;            // dividend width
    localparam int QB   = CB - 1;            // quotient width (q <= |target|)
    localparam int DF   = CB + 3;            // length minus target
    localparam int LW   = DF + RATIO_FRAC;
    localparam int RW   = RATIO_BITS + RB;
    localparam int CW   = (LW > RW) ? LW : RW;
    localparam int NSTG = 8 + L + QB;

    typedef struct packed {
        logic [2:0][CB-1:0] pos;
        logic [2:0][CB-1:0] mag;
        logic [2:0]         neg;
    } t_item;

    // ---------------- configuration registers ----------------
    logic [CB-1:0]         r_cx, r_cy, r_cz;
    logic [RB-1:0]         r_ball_r, r_grain_r;
    logic [RATIO_BITS-1:0] r_ratio;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cx      <= '0;
            r_cy      <= '0;
            r_cz      <= '0;
            r_ball_r  <= RB'(1) << FRAC_BITS;
            r_grain_r <= '0;
            r_ratio   <= RATIO_BITS'(1) << (RATIO_FRAC - 1);
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_CENTER_X: r_cx      <= i_cfg_data[CB-1:0];
                CFG_CENTER_Y: r_cy      <= i_cfg_data[CB-1:0];
                CFG_CENTER_Z: r_cz      <= i_cfg_data[CB-1:0];
                CFG_BALL_R:   r_ball_r  <= i_cfg_data[RB-1:0];
                CFG_GRAIN_R:  r_grain_r <= i_cfg_data[RB-1:0];
                CFG_RATIO:    r_ratio   <= i_cfg_data[RATIO_BITS-1:0];
                default: ;
            endcase
        end
    end

    logic [2:0][CB-1:0] w_ctr;
    assign w_ctr = {r_cz, r_cy, r_cx};

    // ---------------- flow control ----------------
    logic            w_en;
    logic [NSTG-1:0] r_vld;

    assign w_en       = !r_vld[NSTG-1] || i_m_tready;
    assign o_s_tready = w_en;
    assign o_m_tvalid = r_vld[NSTG-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[NSTG-2:0], i_s_tvalid};
        end
    end

    // ---------------- stage 1: offset and magnitude ----------------
    t_item r1_it;
    t_item n1_it;

    always_comb begin
        logic [CB:0] d;
        logic [CB:0] dn;
        n1_it = '0;
        for (int i = 0; i < 3; i++) begin
            n1_it.pos[i] = i_s_tdata[i*CB +: CB];
            d  = {n1_it.pos[i][CB-1], n1_it.pos[i]} - {w_ctr[i][CB-1], w_ctr[i]};
            dn = (CB+1)'(0) - d;
            n1_it.neg[i] = d[CB];
            n1_it.mag[i] = d[CB] ? dn[CB-1:0] : d[CB-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) r1_it <= n1_it;
    end

    // ---------------- stage 2: squares ----------------
    t_item              r2_it;
    logic [2:0][NB-1:0] r2_sq;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r2_it <= r1_it;
            for (int i = 0; i < 3; i++) begin
                r2_sq[i] <= NB'(r1_it.mag[i]) * NB'(r1_it.mag[i]);
            end
        end
    end

    // ---------------- stage 3: sum of squares ----------------
    t_item         r3_it;
    logic [SQ-1:0] r3_sum;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r3_it  <= r2_it;
            r3_sum <= SQ'(r2_sq[0]) + SQ'(r2_sq[1]) + SQ'(r2_sq[2]);
        end
    end

    // ---------------- square root, one result bit per stage ----------------
    t_item         r_sq_it  [L];
    logic [SQ-1:0] r_sq_rem [L];
    logic [L-1:0]  r_sq_res [L];

    for (genvar k = 0; k < L; k++) begin : g_sqrt
        localparam int B = L - 1 - k;
        t_item         w_it;
        logic [SQ-1:0] w_rem, w_trial;
        logic [L-1:0]  w_res;

        if (k == 0) begin : g_first
            assign w_it  = r3_it;
            assign w_rem = r3_sum;
            assign w_res = '0;
        end else begin : g_next
            assign w_it  = r_sq_it[k-1];
            assign w_rem = r_sq_rem[k-1];
            assign w_res = r_sq_res[k-1];
        end

        // (res + 2^B)^2 - res^2, res has no bits at or below B
        assign w_trial = (SQ'(w_res) << (B + 1)) | (SQ'(1) << (2 * B));

        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_sq_it[k] <= w_it;
                if (w_rem >= w_trial) begin
                    r_sq_rem[k] <= w_rem - w_trial;
                    r_sq_res[k] <= w_res | (L'(1) << B);
                end else begin
                    r_sq_rem[k] <= w_rem;
                    r_sq_res[k] <= w_res;
                end
            end
        end
    end

    // ---------------- stage D1: target, distance error, threshold ----------------
    t_item         r4_it;
    logic [L-1:0]  r4_len;
    logic [DF-1:0] r4_adiff;
    logic [RW-1:0] r4_rhs;
    logic [RB-1:0] r4_atgt;
    logic          r4_tneg;

    logic [L-1:0]  w_len;
    logic [CB-1:0] w_tgt, w_tgtn;
    logic [DF-1:0] w_diff, w_diffn;

    assign w_len   = r_sq_res[L-1];
    assign w_tgt   = {1'b0, r_ball_r} - {1'b0, r_grain_r};
    assign w_tgtn  = CB'(0) - w_tgt;
    assign w_diff  = DF'(w_len) - {{(DF-CB){w_tgt[CB-1]}}, w_tgt};
    assign w_diffn = DF'(0) - w_diff;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r4_it    <= r_sq_it[L-1];
            r4_len   <= w_len;
            r4_adiff <= w_diff[DF-1] ? w_diffn : w_diff;
            r4_rhs   <= RW'(r_ratio) * RW'(r_grain_r);
            r4_tneg  <= w_tgt[CB-1];
            r4_atgt  <= w_tgt[CB-1] ? w_tgtn[RB-1:0] : w_tgt[RB-1:0];
        end
    end

    // ---------------- stage D2: snap decision, scaled offsets ----------------
    t_item                 r5_it;
    logic [L-1:0]          r5_len;
    logic                  r5_moved;
    logic                  r5_tneg;
    logic [2:0][NB-2:0]    r5_prod;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r5_it    <= r4_it;
            r5_len   <= r4_len;
            r5_tneg  <= r4_tneg;
            r5_moved <= (r4_len != '0) &&
                        (CW'({r4_adiff, {RATIO_FRAC{1'b0}}}) < CW'(r4_rhs));
            for (int i = 0; i < 3; i++) begin
                r5_prod[i] <= (NB-1)'(r4_atgt) * (NB-1)'(r4_it.mag[i]);
            end
        end
    end

    // ---------------- stage D3: add half length for rounding ----------------
    t_item              r6_it;
    logic [L-1:0]       r6_len;
    logic               r6_moved;
    logic               r6_tneg;
    logic [2:0][NB-1:0] r6_num;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r6_it    <= r5_it;
            r6_len   <= r5_len;
            r6_moved <= r5_moved;
            r6_tneg  <= r5_tneg;
            for (int i = 0; i < 3; i++) begin
                r6_num[i] <= NB'(r5_prod[i]) + NB'(r5_len >> 1);
            end
        end
    end

    // ---------------- divider, one quotient bit per stage ----------------
    t_item              r_dv_it    [QB];
    logic [L-1:0]       r_dv_len   [QB];
    logic               r_dv_moved [QB];
    logic               r_dv_tneg  [QB];
    logic [2:0][NB-1:0] r_dv_rem   [QB];
    logic [2:0][QB-1:0] r_dv_q     [QB];

    for (genvar j = 0; j < QB; j++) begin : g_div
        localparam int B = QB - 1 - j;
        t_item              w_it;
        logic [L-1:0]       w_dlen;
        logic               w_moved, w_tneg;
        logic [2:0][NB-1:0] w_rem;
        logic [2:0][QB-1:0] w_q;
        logic [NB-1:0]      w_dvs;

        if (j == 0) begin : g_first
            assign w_it    = r6_it;
            assign w_dlen  = r6_len;
            assign w_moved = r6_moved;
            assign w_tneg  = r6_tneg;
            assign w_rem   = r6_num;
            assign w_q     = '0;
        end else begin : g_next
            assign w_it    = r_dv_it[j-1];
            assign w_dlen  = r_dv_len[j-1];
            assign w_moved = r_dv_moved[j-1];
            assign w_tneg  = r_dv_tneg[j-1];
            assign w_rem   = r_dv_rem[j-1];
            assign w_q     = r_dv_q[j-1];
        end

        assign w_dvs = NB'(w_dlen) << B;

        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_dv_it[j]    <= w_it;
                r_dv_len[j]   <= w_dlen;
                r_dv_moved[j] <= w_moved;
                r_dv_tneg[j]  <= w_tneg;
                for (int i = 0; i < 3; i++) begin
                    if (w_rem[i] >= w_dvs) begin
                        r_dv_rem[j][i] <= w_rem[i] - w_dvs;
                        r_dv_q[j][i]   <= w_q[i] | (QB'(1) << B);
                    end else begin
                        r_dv_rem[j][i] <= w_rem[i];
                        r_dv_q[j][i]   <= w_q[i];
                    end
                end
            end
        end
    end

    // ---------------- stage F1: apply sign, add center ----------------
    t_item              r7_it;
    logic               r7_moved;
    logic [2:0][CB:0]   r7_sum;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r7_it    <= r_dv_it[QB-1];
            r7_moved <= r_dv_moved[QB-1];
            for (int i = 0; i < 3; i++) begin
                r7_sum[i] <= {w_ctr[i][CB-1], w_ctr[i]} +
                    ((r_dv_tneg[QB-1] ^ r_dv_it[QB-1].neg[i]) ?
                     ((CB+1)'(0) - (CB+1)'(r_dv_q[QB-1][i])) :
                     (CB+1)'(r_dv_q[QB-1][i]));
            end
        end
    end

    // ---------------- stage F2: saturate, select, output register ----------------
    logic [2:0][CB-1:0] r_out;
    logic               r_out_moved;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_out_moved <= r7_moved;
            for (int i = 0; i < 3; i++) begin
                if (!r7_moved) begin
                    r_out[i] <= r7_it.pos[i];
                end else if (r7_sum[i][CB] != r7_sum[i][CB-1]) begin
                    r_out[i] <= r7_sum[i][CB] ? {1'b1, {(CB-1){1'b0}}}
                                              : {1'b0, {(CB-1){1'b1}}};
                end else begin
                    r_out[i] <= r7_sum[i][CB-1:0];
                end
            end
        end
    end

    assign o_m_tdata = DW_OUT'(r_out);
    assign o_m_tuser = r_out_moved;

endmodule

`default_nettype wire

// File: design/snsh_chk.sv
// Port-level checker for snap_points_to_sphere_shell, bound to the top level.
// Depends on snsh_pkg.
`default_nettype none

module snsh_chk #(
    parameter int COORD_BITS = 32,
    localparam int DW_OUT = ((3 * COORD_BITS + 7) / 8) * 8
) (
    input wire logic              i_clk,
    input wire logic              i_rst_n,
    input wire logic              o_s_tready,
    input wire logic              o_m_tvalid,
    input wire logic              i_m_tready,
    input wire logic [DW_OUT-1:0] o_m_tdata,
    input wire logic              o_m_tuser
);
    import snsh_pkg::*;

    // a stalled output beat holds its payload
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata) &&
        $stable(o_m_tuser))
        else $error("output beat changed while stalled");

    // a stalled output holds the whole pipe, so no new input beat
    a_backpressure: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |-> !o_s_tready)
        else $error("input accepted while output stalled");

    // reset empties the pipe
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("output valid right after reset");

endmodule

bind snap_points_to_sphere_shell snsh_chk #(.COORD_BITS(COORD_BITS)) u_snsh_chk (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_s_tready (o_s_tready),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tuser  (o_m_tuser)
);

`default_nettype wire

// File: sim/tb_top.sv
// Self-checking bench for the sphere-shell snapping pipeline.
// Depends on snsh_pkg and snap_points_to_sphere_shell; predicts each output beat in-line.
`default_nettype none

module tb_top;
    import snsh_pkg::*;

    localparam int CB = 32;
    localparam int LAT = 2 * CB + 8;

    typedef struct packed {
        logic signed [31:0] z;
        logic signed [31:0] y;
        logic signed [31:0] x;
    } t_pos;

    typedef struct {
        t_pos p;
        logic moved;
    } t_snap;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [2:0]  i_cfg_idx = '0;
    logic [31:0] i_cfg_data = '0;
    logic        i_s_tvalid = 1'b0;
    logic        o_s_tready;
    logic [95:0] i_s_tdata = '0;
    logic        o_m_tvalid;
    logic        i_m_tready = 1'b0;
    logic [95:0] o_m_tdata;
    logic        o_m_tuser;

    snap_points_to_sphere_shell i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data),
        .i_s_tvalid(i_s_tvalid), .o_s_tready(o_s_tready), .i_s_tdata(i_s_tdata),
        .o_m_tvalid(o_m_tvalid), .i_m_tready(i_m_tready),
        .o_m_tdata(o_m_tdata), .o_m_tuser(o_m_tuser)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // shadow copy of the register bank
    logic signed [31:0] ctr [3];
    logic [30:0] ball_r, grain_r;
    logic [23:0] ratio;

    t_pos   pending_pos[$];   // positions waiting to be sent
    t_snap  snapped_q[$];     // predicted output beats, oldest first
    int     n_err = 0;

    // Predict one beat; wide signed math avoids any overflow of the 32-bit terms.
    function automatic t_snap snap_predict(t_pos p);
        t_snap r;
        logic signed [33:0] d [3];
        logic [32:0] mag [3];
        logic [67:0] sumsq;
        logic [63:0] len, cand;
        logic signed [33:0] tgt;
        logic signed [65:0] diff;
        logic [65:0] adiff;
        logic [127:0] lhs, rhs, num, q;
        logic [32:0] atgt;
        logic signed [65:0] off, sum;
        logic signed [31:0] pin [3];
        logic signed [31:0] pout [3];
        pin[0] = p.x; pin[1] = p.y; pin[2] = p.z;
        sumsq = '0;
        for (int i = 0; i < 3; i++) begin
            d[i] = 34'(pin[i]) - 34'(ctr[i]);
            mag[i] = d[i] < 0 ? 33'(-d[i]) : 33'(d[i]);
            sumsq += 68'(mag[i]) * 68'(mag[i]);
        end
        len = '0;
        for (int b = 35; b >= 0; b--) begin
            cand = len | (64'd1 << b);
            if (128'(cand) * 128'(cand) <= 128'(sumsq)) len = cand;
        end
        tgt = 34'(ball_r) - 34'(grain_r);
        r.moved = 1'b0;
        if (len != 0) begin
            diff = 66'(len) - 66'(tgt);
            adiff = diff < 0 ? 66'(-diff) : 66'(diff);
            lhs = 128'(adiff) << RATIO_FRAC;
            rhs = 128'(ratio) * 128'(grain_r);
            r.moved = lhs < rhs;
        end
        atgt = tgt < 0 ? 33'(-tgt) : 33'(tgt);
        for (int i = 0; i < 3; i++) begin
            if (r.moved) begin
                num = 128'(atgt) * 128'(mag[i]) + 128'(len >> 1);
                q = num / 128'(len);
                if (q > (128'd1 << 62)) q = 128'd1 << 62;
                off = ((tgt < 0) != (d[i] < 0)) ? -66'(q) : 66'(q);
                sum = 66'(ctr[i]) + off;
                if (sum > 66'sh7fffffff) sum = 66'sh7fffffff;
                if (sum < -66'sh80000000) sum = -66'sh80000000;
                pout[i] = sum[31:0];
            end else begin
                pout[i] = pin[i];
            end
        end
        r.p.x = pout[0]; r.p.y = pout[1]; r.p.z = pout[2];
        return r;
    endfunction

    // driver: offers queued positions with random gaps
    int gap_left = 0;
    always @(posedge i_clk) begin
        if (i_s_tvalid && o_s_tready) begin
            snapped_q.push_back(snap_predict(t_pos'(i_s_tdata)));
            void'(pending_pos.pop_front());
        end
        // the head of pending_pos is now the next beat not yet accepted
        if (i_s_tvalid && !o_s_tready) begin
            // hold the beat
        end else if (gap_left > 0) begin
            i_s_tvalid <= 1'b0;
            gap_left <= gap_left - 1;
        end else if (pending_pos.size() > 0 && i_rst_n) begin
            i_s_tvalid <= 1'b1;
            i_s_tdata <= pending_pos[0];
            if ($urandom_range(99) < 25)
                gap_left <= ($urandom_range(9) == 0) ? $urandom_range(40) : $urandom_range(3);
        end else begin
            i_s_tvalid <= 1'b0;
        end
    end

    // monitor with a random receive stall; hold_off forces one long back-pressure run
    int stall_left = 0;
    int hold_off = 0;
    bit stall_on = 1'b1;
    always @(posedge i_clk) begin
        t_snap want;
        t_pos got;
        if (o_m_tvalid && i_m_tready) begin
            got = t_pos'(o_m_tdata);
            if (snapped_q.size() == 0) begin
                $error("output beat with nothing expected");
                n_err++;
            end else begin
                want = snapped_q.pop_front();
                if (got.x !== want.p.x) begin
                    $error("new_x exp %h got %h", want.p.x, got.x); n_err++;
                end
                if (got.y !== want.p.y) begin
                    $error("new_y exp %h got %h", want.p.y, got.y); n_err++;
                end
                if (got.z !== want.p.z) begin
                    $error("new_z exp %h got %h", want.p.z, got.z); n_err++;
                end
                if (o_m_tuser !== want.moved) begin
                    $error("moved exp %b got %b", want.moved, o_m_tuser); n_err++;
                end
            end
        end
        if (hold_off > 0) begin
            hold_off <= hold_off - 1;
            i_m_tready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            i_m_tready <= 1'b0;
        end else begin
            i_m_tready <= i_rst_n;
            if (stall_on && $urandom_range(99) < 20)
                stall_left <= ($urandom_range(9) == 0) ? $urandom_range(50) : $urandom_range(3);
        end
    end

    task automatic cfg_write(t_cfg_idx idx, logic [31:0] val);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CFG_CENTER_X: ctr[0] = val;
            CFG_CENTER_Y: ctr[1] = val;
            CFG_CENTER_Z: ctr[2] = val;
            CFG_BALL_R:   ball_r = val[30:0];
            CFG_GRAIN_R:  grain_r = val[30:0];
            CFG_RATIO:    ratio = val[23:0];
            default: ;
        endcase
    endtask

    task automatic drain;
        while (pending_pos.size() > 0 || snapped_q.size() > 0) @(posedge i_clk);
        repeat (LAT + 10) @(posedge i_clk);
    endtask

    // position near the shell so that many beats actually snap
    function automatic t_pos near_shell();
        t_pos p;
        int signed r, axis;
        r = int'(ball_r) - int'(grain_r) + $signed($urandom_range(8192)) - 4096;
        axis = $urandom_range(2);
        p.x = ctr[0] + ($signed($urandom_range(2048)) - 1024);
        p.y = ctr[1] + ($signed($urandom_range(2048)) - 1024);
        p.z = ctr[2] + ($signed($urandom_range(2048)) - 1024);
        if ($urandom_range(1)) r = -r;
        if (axis == 0) p.x = ctr[0] + r;
        else if (axis == 1) p.y = ctr[1] + r;
        else p.z = ctr[2] + r;
        return p;
    endfunction

    function automatic t_pos rand_pos();
        t_pos p;
        p.x = $urandom; p.y = $urandom; p.z = $urandom;
        return p;
    endfunction

    task automatic random_phase(int n);
        for (int i = 0; i < n; i++)
            pending_pos.push_back($urandom_range(3) != 0 ? near_shell() : rand_pos());
        drain();
    endtask

    initial begin
        t_pos p;
        ctr[0] = 0; ctr[1] = 0; ctr[2] = 0;
        ball_r = 31'd65536; grain_r = '0; ratio = 24'd32768;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset settings: grain radius zero means nothing snaps
        p = '{z: 0, y: 0, x: 32'sd65536}; pending_pos.push_back(p);
        drain();

        cfg_write(CFG_GRAIN_R, 32'h0000_4000);
        cfg_write(CFG_RATIO, 32'hff00_0000 | 24'h0100_00);
        // directed: zero offset, on shell, extremes, off-axis
        p = '0; pending_pos.push_back(p);
        p = '{z: 0, y: 0, x: 32'sd49152}; pending_pos.push_back(p);
        p = '{z: 0, y: -32'sd49000, x: 0}; pending_pos.push_back(p);
        p = '{z: 32'sd30000, y: 32'sd30000, x: 32'sd20000}; pending_pos.push_back(p);
        p = '{z: 32'h7fffffff, y: 32'h7fffffff, x: 32'h7fffffff}; pending_pos.push_back(p);
        p = '{z: 32'h80000000, y: 32'h80000000, x: 32'h80000000}; pending_pos.push_back(p);
        p = '{z: 32'h80000000, y: 32'h7fffffff, x: 0}; pending_pos.push_back(p);
        p = '{z: -1, y: -1, x: -1}; pending_pos.push_back(p);
        p = '{z: 32'h55555555, y: 32'haaaaaaaa, x: 32'h0f0f0f0f}; pending_pos.push_back(p);
        drain();

        // negative target: grain bigger than ball, huge ratio
        cfg_write(CFG_BALL_R, 32'h0000_1000);
        cfg_write(CFG_GRAIN_R, 32'h0000_3000);
        cfg_write(CFG_RATIO, 32'h00ff_ffff);
        p = '{z: 0, y: 0, x: 32'sd8192}; pending_pos.push_back(p);
        p = '{z: 32'sd100, y: -32'sd8000, x: 32'sd3}; pending_pos.push_back(p);
        p = '{z: 32'sd1, y: 0, x: 0}; pending_pos.push_back(p);
        drain();

        // extreme center and radii: saturation of the snapped sum
        cfg_write(CFG_CENTER_X, 32'h7fff_ffff);
        cfg_write(CFG_CENTER_Y, 32'h8000_0000);
        cfg_write(CFG_CENTER_Z, 32'h0000_0000);
        cfg_write(CFG_BALL_R, 32'hffff_ffff);
        cfg_write(CFG_GRAIN_R, 32'h0000_0000);
        cfg_write(CFG_GRAIN_R, 32'h7fff_ffff);
        cfg_write(CFG_RATIO, 32'h00ff_ffff);
        p = '{z: 32'sd5, y: 32'h8000_0000, x: 0}; pending_pos.push_back(p);
        p = '{z: 0, y: 0, x: 32'h7fff_fff0}; pending_pos.push_back(p);
        p = '{z: 32'h7fffffff, y: 0, x: 32'h80000000}; pending_pos.push_back(p);
        drain();
        // extra index beyond the bank must do nothing
        @(posedge i_clk);
        i_cfg_we <= 1'b1; i_cfg_idx <= 3'd7; i_cfg_data <= 32'hffff_ffff;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;

        // random phases across several settings
        cfg_write(CFG_CENTER_X, 32'h0001_0000);
        cfg_write(CFG_CENTER_Y, 32'hffff_0000);
        cfg_write(CFG_CENTER_Z, 32'h0000_8000);
        cfg_write(CFG_BALL_R, 32'h0004_0000);
        cfg_write(CFG_GRAIN_R, 32'h0000_2000);
        cfg_write(CFG_RATIO, 32'h0000_8000);
        random_phase(250);

        // long receiver hold-off while the sender keeps offering
        hold_off = 3 * LAT;
        random_phase(200);

        for (int k = 0; k < 2; k++) begin
            cfg_write(CFG_CENTER_X, $urandom);
            cfg_write(CFG_CENTER_Y, $urandom);
            cfg_write(CFG_CENTER_Z, $urandom);
            cfg_write(CFG_BALL_R, $urandom_range(32'h0100_0000));
            cfg_write(CFG_GRAIN_R, $urandom_range(32'h0008_0000));
            cfg_write(CFG_RATIO, $urandom);
            random_phase(150);
        end

        cfg_write(CFG_CENTER_X, 0);
        cfg_write(CFG_CENTER_Y, 0);
        cfg_write(CFG_CENTER_Z, 0);
        cfg_write(CFG_BALL_R, 32'h0000_8000);
        cfg_write(CFG_GRAIN_R, 32'h0000_c000);
        cfg_write(CFG_RATIO, 32'h0003_0000);
        stall_on = 1'b0;
        random_phase(180);

        if (n_err == 0) begin
            $display("tb_top: clean");
        end else begin
            $display("tb_top: errors");
        end
        $finish;
    end

    initial begin
        #24000000;
        $display("tb_top: errors");
        $finish;
    end
endmodule

`default_nettype wire

// File: sim.f
design/snsh_pkg.sv
design/snap_points_to_sphere_shell.sv
design/snsh_chk.sv
sim/tb_top.sv
